[rtl/core/dsv_pkg.sv]
// Shared types, constants and codes of the DSA signature checker.
`timescale 1ns / 1ps
`default_nettype none
package dsv_pkg;
	localparam int P_BITS = 64;
	localparam int Q_BITS = 32;
	localparam int CNT_BITS = $clog2(P_BITS);
	localparam int IDX_BITS = 3;
	localparam int EXP_CNT_BITS = $clog2(Q_BITS);

	localparam logic [IDX_BITS-1:0] CFG_PRIME = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] CFG_ORDER = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] CFG_GEN   = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] CFG_PUB   = IDX_BITS'(3);

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_NOINV = 2'd2,
		STAT_DIFF  = 2'd3
	} status_t;

	typedef struct packed {
		logic [P_BITS-1:0] prime;
		logic [Q_BITS-1:0] order;
		logic [P_BITS-1:0] gen;
		logic [P_BITS-1:0] pub;
	} cfg_t;

	// request to the shared modular multiply unit
	typedef struct packed {
		logic              start;
		logic              half;     // multiplier is Q_BITS wide
		logic [P_BITS-1:0] mcand;
		logic [P_BITS-1:0] mplier;
		logic [P_BITS-1:0] modulus;
	} mm_req_t;

	typedef struct packed {
		logic              done;
		logic [P_BITS-1:0] result;
		logic [Q_BITS-1:0] quot;     // reduction flags, the quotient when mcand is 1
	} mm_rsp_t;
endpackage
`default_nettype wire

[rtl/core/dsv_if.sv]
// Valid/ready channel interfaces for signature words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface dsv_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] sig_r;
	logic [31:0] sig_s;
	logic [31:0] msg_hash;
	modport source (output valid, sig_r, sig_s, msg_hash, input ready);
	modport sink (input valid, sig_r, sig_s, msg_hash, output ready);
endinterface

interface dsv_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [1:0]  status;
	logic [31:0] check_value;
	modport source (output valid, valid_res, status, check_value, input ready);
	modport sink (input valid, valid_res, status, check_value, output ready);
endinterface
`default_nettype wire

[rtl/core/dsv_cfg.sv]
// Domain parameter and public key registers.
`timescale 1ns / 1ps
`default_nettype none
module dsv_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [dsv_pkg::IDX_BITS-1:0]  cfg_index,
	input  wire logic [dsv_pkg::P_BITS-1:0]    cfg_data,
	output dsv_pkg::cfg_t                      cfg
);
	import dsv_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prime <= P_BITS'(2);
			cfg_q.order <= Q_BITS'(2);
			cfg_q.gen   <= P_BITS'(1);
			cfg_q.pub   <= P_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRIME: cfg_q.prime <= cfg_data;
				CFG_ORDER: cfg_q.order <= cfg_data[Q_BITS-1:0];
				CFG_GEN:   cfg_q.gen   <= cfg_data;
				CFG_PUB:   cfg_q.pub   <= cfg_data;
				default: ; // unknown index ignored
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

[rtl/core/dsv_modmul.sv]
// Shared bit-serial modular multiply unit (double and add, MSB first).
`timescale 1ns / 1ps
`default_nettype none
module dsv_modmul (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dsv_pkg::mm_req_t req,
	output dsv_pkg::mm_rsp_t rsp
);
	import dsv_pkg::*;

	logic [P_BITS-1:0]   acc_q, mpl_q, mcand_q, mod_q;
	logic [Q_BITS-1:0]   quot_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                run_q, done_q;

	logic [P_BITS:0]   dbl, dbl_r, sum, sum_r;
	logic              dbl_ge, sum_ge;

	// acc < mod holds, so each add needs at most one subtract
	always_comb begin
		dbl    = {acc_q, 1'b0};
		dbl_ge = dbl >= {1'b0, mod_q};
		dbl_r  = dbl_ge ? dbl - {1'b0, mod_q} : dbl;
		sum    = dbl_r + (mpl_q[P_BITS-1] ? {1'b0, mcand_q} : '0);
		sum_ge = sum >= {1'b0, mod_q};
		sum_r  = sum_ge ? sum - {1'b0, mod_q} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.half ? CNT_BITS'(Q_BITS - 1) : CNT_BITS'(P_BITS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q   <= '0;
			mcand_q <= req.mcand;
			mod_q   <= req.modulus;
			mpl_q   <= req.half ? {req.mplier[Q_BITS-1:0], {(P_BITS-Q_BITS){1'b0}}}
			                    : req.mplier;
		end else if (run_q) begin
			acc_q  <= sum_r[P_BITS-1:0];
			mpl_q  <= {mpl_q[P_BITS-2:0], 1'b0};
			quot_q <= {quot_q[Q_BITS-2:0], dbl_ge | sum_ge};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;
	assign rsp.quot   = quot_q;

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && !req.start |-> acc_q < mod_q)
		else $error("accumulator left the residue range");
endmodule
`default_nettype wire

[rtl/core/dsa_signature_verify.sv]
// Top level of the DSA signature checker: sequencer around one modular multiply unit.
`timescale 1ns / 1ps
`default_nettype none
// Checks one signature word (r, s, hash) against the loaded domain p, q, g, y
// and returns one result word: status, accept flag and the computed v. Load
// the registers (0 p, 1 q, 2 g, 3 y) only while no word is in flight.
// Everything runs on one bit-serial modular multiplier that retires one
// multiplier bit per clock. The inverse of s takes one division and one
// product per Euclid step (up to about 46 steps). Then two q-products, two
// base reductions, two exponentiations of 32 squarings plus one multiply per
// set exponent bit, one p-product and a final mod q. A range failure
// answers without any multiplier work, and a missing inverse or a p below
// two ends the work early. The input is not ready while a word is in work
// or a result waits.
module dsa_signature_verify (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	dsv_in_if.sink                            in_ch,
	dsv_out_if.source                         out_ch,
	input  wire logic                         cfg_we,
	input  wire logic [dsv_pkg::IDX_BITS-1:0] cfg_index,
	input  wire logic [dsv_pkg::P_BITS-1:0]   cfg_data
);
	import dsv_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_DIV  = 11'b00000000010, // Euclid: a mod b, quotient
		ST_MUL  = 11'b00000000100, // Euclid: quotient * t1 mod q
		ST_U1   = 11'b00000001000,
		ST_U2   = 11'b00000010000,
		ST_GRED = 11'b00000100000, // g mod p
		ST_YRED = 11'b00001000000, // y mod p
		ST_SQ   = 11'b00010000000,
		ST_ML   = 11'b00100000000,
		ST_AB   = 11'b01000000000,
		ST_VRED = 11'b10000000000  // x mod q
	} state_t;

	cfg_t    cfg;
	mm_req_t req;
	mm_rsp_t rsp;

	dsv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dsv_modmul u_mm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	state_t state_q;
	logic   go_q;
	logic   second_q;     // working on y^u2
	logic   out_valid_q;
	logic   res_ok_q;
	status_t res_stat_q;
	logic [Q_BITS-1:0] res_v_q;

	logic [Q_BITS-1:0] r_q, h_q;
	logic [Q_BITS-1:0] ea_q, eb_q, rem_q, qt_q, t0_q, t1_q;
	logic [Q_BITS-1:0] e1_q, e2_q;
	logic [P_BITS-1:0] gb_q, yb_q, pacc_q, pa_q;
	logic [EXP_CNT_BITS-1:0] cnt_q;

	logic in_acc, range_ok, exp_bit;
	logic [Q_BITS-1:0] prod, tn, rem;

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign range_ok    = (in_ch.sig_r != '0) && (in_ch.sig_r < cfg.order)
	                  && (in_ch.sig_s != '0) && (in_ch.sig_s < cfg.order);

	assign prod    = rsp.result[Q_BITS-1:0];
	assign rem     = rsp.result[Q_BITS-1:0];
	// t0 - qt*t1 kept in [0, q)
	assign tn      = (t0_q >= prod) ? t0_q - prod : t0_q + (cfg.order - prod);
	assign exp_bit = second_q ? e2_q[cnt_q] : e1_q[cnt_q];

	always_comb begin
		req.start   = go_q;
		req.half    = 1'b0;
		req.mcand   = P_BITS'(1);
		req.mplier  = pacc_q;
		req.modulus = cfg.prime;
		case (state_q)
			ST_DIV: begin
				req.half    = 1'b1;
				req.mplier  = P_BITS'(ea_q);
				req.modulus = P_BITS'(eb_q);
			end
			ST_MUL: begin
				req.half    = 1'b1;
				req.mcand   = P_BITS'(t1_q);
				req.mplier  = P_BITS'(qt_q);
				req.modulus = P_BITS'(cfg.order);
			end
			ST_U1, ST_U2: begin
				req.half    = 1'b1;
				req.mcand   = P_BITS'(t1_q);
				req.mplier  = P_BITS'((state_q == ST_U1) ? h_q : r_q);
				req.modulus = P_BITS'(cfg.order);
			end
			ST_GRED: req.mplier = cfg.gen;
			ST_YRED: req.mplier = cfg.pub;
			ST_SQ:   req.mcand  = pacc_q;
			ST_ML:   req.mcand  = second_q ? yb_q : gb_q;
			ST_AB:   req.mcand  = pa_q;
			ST_VRED: req.modulus = P_BITS'(cfg.order);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
			cnt_q       <= '0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!range_ok) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_DIV;
							go_q    <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (rsp.done) begin
						if (rem == '0) begin
							if (eb_q != Q_BITS'(1)) begin
								out_valid_q <= 1'b1; // no inverse
								state_q     <= ST_IDLE;
							end else begin
								state_q <= ST_U1;
								go_q    <= 1'b1;
							end
						end else begin
							state_q <= ST_MUL;
							go_q    <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					if (rsp.done) begin
						state_q <= ST_DIV;
						go_q    <= 1'b1;
					end
				end
				ST_U1: begin
					if (rsp.done) begin
						state_q <= ST_U2;
						go_q    <= 1'b1;
					end
				end
				ST_U2: begin
					if (rsp.done) begin
						if (cfg.prime < P_BITS'(2)) begin
							out_valid_q <= 1'b1; // v is 0, never equals r
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_GRED;
							go_q    <= 1'b1;
						end
					end
				end
				ST_GRED: begin
					if (rsp.done) begin
						state_q <= ST_YRED;
						go_q    <= 1'b1;
					end
				end
				ST_YRED: begin
					if (rsp.done) begin
						state_q  <= ST_SQ;
						go_q     <= 1'b1;
						second_q <= 1'b0;
						cnt_q    <= EXP_CNT_BITS'(Q_BITS - 1);
					end
				end
				ST_SQ, ST_ML: begin
					if (rsp.done) begin
						go_q <= 1'b1;
						if (state_q == ST_SQ && exp_bit) begin
							state_q <= ST_ML;
						end else if (cnt_q != '0) begin
							cnt_q   <= cnt_q - 1'b1;
							state_q <= ST_SQ;
						end else if (!second_q) begin
							second_q <= 1'b1;
							cnt_q    <= EXP_CNT_BITS'(Q_BITS - 1);
							state_q  <= ST_SQ;
						end else begin
							state_q <= ST_AB;
						end
					end
				end
				ST_AB: begin
					if (rsp.done) begin
						state_q <= ST_VRED;
						go_q    <= 1'b1;
					end
				end
				ST_VRED: begin
					if (rsp.done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					r_q  <= in_ch.sig_r;
					h_q  <= in_ch.msg_hash;
					ea_q <= cfg.order;
					eb_q <= in_ch.sig_s;
					t0_q <= '0;
					t1_q <= Q_BITS'(1);
					res_ok_q   <= 1'b0;
					res_stat_q <= STAT_RANGE;
					res_v_q    <= '0;
				end
			end
			ST_DIV: begin
				if (rsp.done) begin
					rem_q <= rem;
					qt_q  <= rsp.quot;
					if (rem == '0 && eb_q != Q_BITS'(1))
						res_stat_q <= STAT_NOINV;
				end
			end
			ST_MUL: begin
				if (rsp.done) begin
					ea_q <= eb_q;
					eb_q <= rem_q;
					t0_q <= t1_q;
					t1_q <= tn;
				end
			end
			ST_U1: if (rsp.done) e1_q <= rsp.result[Q_BITS-1:0];
			ST_U2: begin
				if (rsp.done) begin
					e2_q <= rsp.result[Q_BITS-1:0];
					res_stat_q <= STAT_DIFF;
				end
			end
			ST_GRED: if (rsp.done) gb_q <= rsp.result;
			ST_YRED: if (rsp.done) begin
				yb_q   <= rsp.result;
				pacc_q <= P_BITS'(1);
			end
			ST_SQ, ST_ML: begin
				if (rsp.done) begin
					if (!(state_q == ST_SQ && exp_bit) && cnt_q == '0 && !second_q) begin
						pa_q   <= rsp.result;  // g^u1 done, restart for y^u2
						pacc_q <= P_BITS'(1);
					end else begin
						pacc_q <= rsp.result;
					end
				end
			end
			ST_AB: if (rsp.done) pacc_q <= rsp.result;
			ST_VRED: begin
				if (rsp.done) begin
					res_v_q    <= rsp.result[Q_BITS-1:0];
					res_ok_q   <= rsp.result[Q_BITS-1:0] == r_q;
					res_stat_q <= (rsp.result[Q_BITS-1:0] == r_q) ? STAT_OK : STAT_DIFF;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.valid_res   = res_ok_q;
	assign out_ch.status      = res_stat_q;
	assign out_ch.check_value = res_v_q;

	a_no_result_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !out_valid_q)
		else $error("result word pending while a word is in work");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q || state_q != ST_IDLE)
		else $error("accepted word neither answered nor started");

	a_flag_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_ok_q == (res_stat_q == STAT_OK)))
		else $error("accept flag disagrees with status");

	a_inverse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_U1 |-> t1_q < cfg.order)
		else $error("inverse not reduced mod q");
endmodule
`default_nettype wire
